[src/siq_pkg.sv]
`default_nettype none
package siq_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int VALUE_WIDTH_DEFAULT = 8;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } siq_kind_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } siq_op_t;

endpackage
`default_nettype wire

[src/sorted_insert_queue_top.sv]
// Sorted queue of up to DEPTH unsigned values built as a row of cells that
// shift toward the tail on an insert and toward the head on a pop, with the
// smallest value always held in the head cell. Every cycle may carry a
// transfer: busy stays low, each accepted item passes through the cell
// row, and its result appears on the next cycle with done high for exactly
// that one cycle. The receiver cannot stall, so results must be captured
// when done is high. An insert into a full queue and a pop from an empty
// queue leave the contents unchanged and report failure.
`default_nettype none
module sorted_insert_queue_top #(
  parameter int DEPTH       = siq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = siq_pkg::VALUE_WIDTH_DEFAULT,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   kind,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output logic                        done,
  output logic      [VALUE_WIDTH-1:0] popped_value,
  output logic                        pop_valid,
  output logic                        insert_ok,
  output logic      [CW-1:0]          fill_count
);
  import siq_pkg::*;

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic                   accept;
  siq_op_t                op;
  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic                   cell_move  [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    op.ins = accept && (kind == KIND_INSERT) && (count != FULL_COUNT);
    op.pop = accept && (kind == KIND_POP) && (count != '0);
    count_next = count;
    if (op.ins) begin
      count_next = count + CW'(1);
    end else if (op.pop) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_value;
    logic                   left_move;
    logic [VALUE_WIDTH-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_move  = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_move  = cell_move[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    siq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .occupied   (CW'(i) < count),
      .ins_value  (value),
      .left_value (left_value),
      .left_move  (left_move),
      .right_value(right_value),
      .value      (cell_value[i]),
      .move       (cell_move[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    popped_value <= op.pop ? cell_value[0] : '0;
    pop_valid    <= op.pop;
    insert_ok    <= op.ins;
    fill_count   <= count_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("fill count exceeds depth");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> !(pop_valid && insert_ok))
    else $error("pop and insert reported together");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept && !rst))
    else $error("result strobe does not follow accepted transfer");

  a_fill_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (fill_count == count))
    else $error("reported fill count differs from held count");

endmodule
`default_nettype wire

[src/siq_cell.sv]
`default_nettype none
module siq_cell #(
  parameter int VALUE_WIDTH = 8
) (
  input  wire logic                   clk,
  input  wire siq_pkg::siq_op_t       op,
  input  wire logic                   occupied,
  input  wire logic [VALUE_WIDTH-1:0] ins_value,
  input  wire logic [VALUE_WIDTH-1:0] left_value,
  input  wire logic                   left_move,
  input  wire logic [VALUE_WIDTH-1:0] right_value,
  output logic      [VALUE_WIDTH-1:0] value,
  output logic                        move
);
  import siq_pkg::*;

  // Cells hold values in ascending order from the head; an insert goes at the
  // first cell that is empty or holds a larger value, and the cells after it
  // take the value of their left neighbor.
  assign move = !occupied || (value > ins_value);

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (left_move) begin
        value <= left_value;
      end else if (move) begin
        value <= ins_value;
      end
    end else if (op.pop) begin
      value <= right_value;
    end
  end

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
  import siq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int VW = VALUE_WIDTH_DEFAULT;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_ROWS = 16;

  typedef struct packed {
    logic [VW-1:0] popped_value;
    logic          pop_valid;
    logic          insert_ok;
    logic [CW-1:0] fill_count;
  } queue_result_t;

  typedef struct {
    siq_kind_t     kind;
    logic [VW-1:0] value;
    int            count;
    bit            typed;
    queue_result_t want;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          start;
  logic          busy;
  logic          kind;
  logic [VW-1:0] value;
  logic          done;
  logic [VW-1:0] popped_value;
  logic          pop_valid;
  logic          insert_ok;
  logic [CW-1:0] fill_count;

  logic [VW-1:0] held_values [DEPTH];
  int            held_count;
  queue_result_t awaited_results [$];
  int            mismatches;
  int            cycles;

  stim_row_t stim_rows [NUM_ROWS] = '{
    '{KIND_POP,    8'd0,   1,  1'b1, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_INSERT, 8'd0,   1,  1'b1, '{8'd0,  1'b0, 1'b1, 6'd1}},
    '{KIND_INSERT, 8'd255, 1,  1'b1, '{8'd0,  1'b0, 1'b1, 6'd2}},
    '{KIND_INSERT, 8'd128, 1,  1'b0, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_INSERT, 8'd128, 1,  1'b0, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_INSERT, 8'd1,   1,  1'b0, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_POP,    8'd0,   1,  1'b1, '{8'd0,  1'b1, 1'b0, 6'd4}},
    '{KIND_POP,    8'd170, 1,  1'b0, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_POP,    8'd0,   3,  1'b0, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_POP,    8'd255, 1,  1'b1, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_INSERT, 8'd85,  32, 1'b0, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_INSERT, 8'd170, 1,  1'b1, '{8'd0,  1'b0, 1'b0, 6'd32}},
    '{KIND_POP,    8'd0,   1,  1'b1, '{8'd85, 1'b1, 1'b0, 6'd31}},
    '{KIND_INSERT, 8'd255, 1,  1'b0, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_POP,    8'd0,   32, 1'b0, '{8'd0,  1'b0, 1'b0, 6'd0}},
    '{KIND_POP,    8'd0,   1,  1'b1, '{8'd0,  1'b0, 1'b0, 6'd0}}
  };

  sorted_insert_queue_top #(
    .DEPTH(DEPTH),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .value(value),
    .done(done),
    .popped_value(popped_value),
    .pop_valid(pop_valid),
    .insert_ok(insert_ok),
    .fill_count(fill_count)
  );

  always #5 clk = ~clk;

  function automatic queue_result_t next_queue_result(siq_kind_t k, logic [VW-1:0] v);
    queue_result_t res;
    int pos;
    bit found;
    res = '0;
    found = 1'b0;
    if (k == KIND_INSERT) begin
      if (held_count < DEPTH) begin
        pos = held_count;
        for (int i = 0; i < held_count; i++) begin
          if (!found && v >= held_values[i]) begin
            pos = i;
            found = 1'b1;
          end
        end
        for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
        held_values[pos] = v;
        held_count++;
        res.insert_ok = 1'b1;
      end
    end else if (held_count > 0) begin
      held_count--;
      res.popped_value = held_values[held_count];
      res.pop_valid = 1'b1;
    end
    res.fill_count = CW'(held_count);
    return res;
  endfunction

  task automatic idle_sender(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_item(siq_kind_t k, logic [VW-1:0] v, bit typed, queue_result_t want);
    queue_result_t got;
    start <= 1'b1;
    kind <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = next_queue_result(k, v);
    awaited_results.push_back(typed ? want : got);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(int idle_pct, int n_items);
    int sent;
    int ins_pct;
    int burst;
    siq_kind_t k;
    logic [VW-1:0] v;
    bit halfway_done;
    sent = 0;
    halfway_done = 1'b0;
    while (sent < n_items) begin
      case ($urandom_range(3))
        0: ins_pct = 15;
        1: ins_pct = 50;
        2: ins_pct = 85;
        default: ins_pct = 98;
      endcase
      burst = $urandom_range(60, 8);
      repeat (burst) begin
        idle_sender(idle_pct);
        k = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_POP;
        case ($urandom_range(9))
          0: v = '0;
          1: v = '1;
          2: v = VW'($urandom_range(3) * 85);
          default: v = VW'($urandom);
        endcase
        send_item(k, v, 1'b0, '0);
        sent++;
      end
      if (!halfway_done && sent >= n_items / 2) begin
        drain_results();
        halfway_done = 1'b1;
      end
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    queue_result_t exp_r;
    queue_result_t act_r;
    if (!rst && done) begin
      act_r = '{popped_value, pop_valid, insert_ok, fill_count};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: popped=%0d valid=%0b ok=%0b fill=%0d",
                   act_r.popped_value, act_r.pop_valid, act_r.insert_ok, act_r.fill_count);
      end else begin
        exp_r = awaited_results.pop_front();
        if (act_r !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: popped=%0d/%0d valid=%0b/%0b ok=%0b/%0b fill=%0d/%0d (exp/act)",
                     exp_r.popped_value, act_r.popped_value, exp_r.pop_valid, act_r.pop_valid,
                     exp_r.insert_ok, act_r.insert_ok, exp_r.fill_count, act_r.fill_count);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    held_count = 0;
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_INSERT;
    value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[r]) begin
      repeat (stim_rows[r].count)
        send_item(stim_rows[r].kind, stim_rows[r].value, stim_rows[r].typed, stim_rows[r].want);
    end
    drain_results();

    run_random_phase(37, 560);
    run_random_phase(48, 560);
    run_random_phase(0, 560);

    repeat (4) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
